// ===== rtl/core/c3cf_pkg.sv =====
// Shared types and constants for the 3x3 clamp filter.
`default_nettype none
package c3cf_pkg;

    localparam int PIX_W  = 24;
    localparam int CHAN_W = 8;
    localparam int COEF_W = 16;
    localparam int ROW_W  = 48;
    localparam int RECIP_W = 24;
    localparam int SUM_W  = 29;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int FRAC_SHIFT = 24;
    localparam int QDEPTH = 2;

    localparam logic [2:0] CFG_COEF_TOP = 3'd0;
    localparam logic [2:0] CFG_COEF_MID = 3'd1;
    localparam logic [2:0] CFG_COEF_BOT = 3'd2;
    localparam logic [2:0] CFG_RECIP    = 3'd3;
    localparam logic [2:0] CFG_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_HEIGHT   = 3'd5;
    localparam logic [2:0] CFG_CHANS    = 3'd6;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic [8:0][PIX_W-1:0] win;
        logic                  interior;
        logic                  last;
        logic [1:0]            chans;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/core/c3cf_front.sv =====
// Front end: input handshake, line stores, window and output position tracking.
`default_nettype none
module c3cf_front #(
    parameter int MAX_LINE  = 1920,
    parameter int MAX_CHANS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tuser,
    input  wire logic [10:0] image_width,
    input  wire logic [11:0] image_height,
    input  wire logic [1:0]  channel_count,
    output c3cf_pkg::job_t   job,
    output logic             push,
    input  wire logic        q_full
);
    localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_PROC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [23:0] bank_top [MAX_LINE];
    logic [23:0] bank_mid [MAX_LINE];
    logic [23:0] top_rd_reg, mid_rd_reg;

    logic [8:0][23:0] win_reg, win_next;
    logic [11:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [10:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [23:0] pix_reg;
    logic [AW-1:0] idx_reg, idx;
    logic flush_reg, ready_reg, valid_reg;

    logic [12:0] w, h;
    logic [1:0] chans;
    logic accept, in_ok, interior, last;

    always_comb
    begin
        if (image_width < 11'd3)
            w = 13'd3;
        else if ({2'b0, image_width} > 13'(MAX_LINE))
            w = 13'(MAX_LINE);
        else
            w = {2'b0, image_width};
        h = (image_height < 12'd3) ? 13'd3 : {1'b0, image_height};
        if (channel_count == 2'd0)
            chans = 2'd1;
        else if (32'(channel_count) > MAX_CHANS)
            chans = 2'(MAX_CHANS);
        else
            chans = channel_count;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !q_full;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign idx = ({2'b0, in_col_reg} < w) ? AW'(in_col_reg) : '0;
    assign in_ok = (s_axis_tuser == c3cf_pkg::CMD_PIXEL) ? ({1'b0, in_row_reg} < h)
                                                         : ({1'b0, in_row_reg} >= h);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg <= bank_top[idx];
            mid_rd_reg <= bank_mid[idx];
        end
        if (state_reg == S_PROC && valid_reg && !flush_reg)
        begin
            bank_top[idx_reg] <= mid_rd_reg;
            bank_mid[idx_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg   <= s_axis_tdata;
            idx_reg   <= idx;
            flush_reg <= s_axis_tuser;
            ready_reg <= (in_row_reg >= 12'd2) || (in_row_reg == 12'd1 && in_col_reg >= 11'd1);
        end
    end

    assign interior = (out_row_reg >= 12'd1) && ({1'b0, out_row_reg} + 13'd1 < h)
                   && (out_col_reg >= 11'd1) && ({2'b0, out_col_reg} + 13'd1 < w);
    assign last = ({1'b0, out_row_reg} + 13'd1 >= h) && ({2'b0, out_col_reg} + 13'd1 >= w);

    always_comb
    begin
        state_next   = state_reg;
        win_next     = win_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        push         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_PROC;
            end
            S_PROC:
            begin
                state_next = S_IDLE;
                if (valid_reg)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        win_next[i*3]   = win_reg[i*3+1];
                        win_next[i*3+1] = win_reg[i*3+2];
                    end
                    win_next[2] = top_rd_reg;
                    win_next[5] = mid_rd_reg;
                    win_next[8] = flush_reg ? 24'd0 : pix_reg;
                    if (flush_reg)
                        in_col_next = in_col_reg + 11'd1;
                    else if ({2'b0, in_col_reg} + 13'd1 >= w)
                    begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + 12'd1;
                    end
                    else
                        in_col_next = in_col_reg + 11'd1;
                    if (flush_reg || ready_reg)
                    begin
                        push = 1'b1;
                        if (last)
                        begin
                            in_row_next  = '0;
                            in_col_next  = '0;
                            out_row_next = '0;
                            out_col_next = '0;
                        end
                        else if ({2'b0, out_col_reg} + 13'd1 >= w)
                        begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + 12'd1;
                        end
                        else
                            out_col_next = out_col_reg + 11'd1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign job = {win_next, interior, last, chans};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            win_reg     <= '0;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            if (accept)
                valid_reg <= in_ok;
        end
    end

    a_proc_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROC |=> state_reg == S_IDLE) else $error("front stuck");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full) else $error("push into full queue");
    a_push_proc: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> state_reg == S_PROC && $past(accept)) else $error("stray push");

endmodule
`default_nettype wire

// ===== rtl/core/c3cf_queue.sv =====
// Short job queue between front and back.
`default_nettype none
module c3cf_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  c3cf_pkg::job_t      push_job,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output c3cf_pkg::job_t      head
);
    localparam int PW = $clog2(c3cf_pkg::QDEPTH);

    c3cf_pkg::job_t mem_reg [c3cf_pkg::QDEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0] cnt_reg;

    assign full      = (cnt_reg == (PW+1)'(c3cf_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== rtl/core/c3cf_back.sv =====
// Back end: weighted sum, reciprocal scaling, clamp and output register.
`default_nettype none
module c3cf_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    input  c3cf_pkg::job_t   job,
    output logic             pop,
    input  wire logic [47:0] coef_row_top,
    input  wire logic [47:0] coef_row_mid,
    input  wire logic [47:0] coef_row_bot,
    input  wire logic signed [23:0] recip_divisor,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,
    output logic             m_axis_tlast
);
    localparam int SW = c3cf_pkg::SUM_W;
    localparam int PW = c3cf_pkg::PROD_W;

    logic advance;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic signed [SW-1:0] sum [3];
    logic signed [SW-1:0] s1_sum_reg [3];
    logic signed [PW-1:0] s2_prod_reg [3];
    logic [23:0] s1_ctr_reg, s2_ctr_reg, out_data_reg;
    logic [1:0] s1_ch_reg, s2_ch_reg;
    logic s1_int_reg, s2_int_reg, s1_last_reg, s2_last_reg, out_last_reg;
    logic [2:0][47:0] rows;
    logic [23:0] res;

    assign advance = !(out_valid_reg && !m_axis_tready);
    assign pop     = advance && job_valid;
    assign rows    = {coef_row_bot, coef_row_mid, coef_row_top};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = '0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    sum[k] = sum[k] + SW'($signed(rows[i][16*j +: 16])
                             * $signed({1'b0, job.win[i*3+j][8*k +: 8]}));
        end
    end

    always_comb
    begin
        res = '0;
        for (int k = 0; k < 3; k++)
        begin
            if (k < 32'(s2_ch_reg))
            begin
                if (!s2_int_reg)
                    res[8*k +: 8] = s2_ctr_reg[8*k +: 8];
                else if (s2_prod_reg[k] <= 0)
                    res[8*k +: 8] = 8'd0;
                else if (s2_prod_reg[k][PW-1:c3cf_pkg::FRAC_SHIFT] > 29'd255)
                    res[8*k +: 8] = 8'd255;
                else
                    res[8*k +: 8] = s2_prod_reg[k][c3cf_pkg::FRAC_SHIFT +: 8];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_sum_reg[k]  <= sum[k];
                s2_prod_reg[k] <= PW'(s1_sum_reg[k]) * PW'(recip_divisor);
            end
            s1_ctr_reg   <= job.win[4];
            s1_ch_reg    <= job.chans;
            s1_int_reg   <= job.interior;
            s1_last_reg  <= job.last;
            s2_ctr_reg   <= s1_ctr_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_int_reg   <= s1_int_reg;
            s2_last_reg  <= s1_last_reg;
            out_data_reg <= res;
            out_last_reg <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_stage_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && advance |=> out_valid_reg) else $error("result lost");

endmodule
`default_nettype wire

// ===== rtl/core/conv3x3_clamp_filter.sv =====
// Top level of the 3x3 convolution filter with clamp.
// Each request: line-store read, then window shift (tready low meanwhile).
// Path to output valid: input regs, job queue, sum, scale and output regs.
// Back end is a 3-stage pipeline (sum, scale, clamp) behind a 2-entry queue.
// Async active-low reset clears counters, window and config to defaults.
// Line stores are not cleared; unwritten entries feed border pixels only.
`default_nettype none
module conv3x3_clamp_filter #(
    parameter int MAX_LINE  = 1920,
    parameter int MAX_CHANS = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // in_chan0, in_chan1, in_chan2
    input  wire logic        s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // out_chan0, out_chan1, out_chan2
    output logic             m_axis_tlast,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_idx,
    input  wire logic [47:0] cfg_data
);
    logic [47:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [23:0] recip_reg;
    logic [10:0] width_reg;
    logic [11:0] height_reg;
    logic [1:0]  chans_reg;

    c3cf_pkg::job_t push_job, head_job;
    logic q_push, q_full;
    logic q_ne, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_top_reg <= 48'd0;
            coef_mid_reg <= 48'd256;
            coef_bot_reg <= 48'd0;
            recip_reg    <= 24'd65536;
            width_reg    <= 11'd1920;
            height_reg   <= 12'd1080;
            chans_reg    <= 2'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                c3cf_pkg::CFG_COEF_TOP: coef_top_reg <= cfg_data;
                c3cf_pkg::CFG_COEF_MID: coef_mid_reg <= cfg_data;
                c3cf_pkg::CFG_COEF_BOT: coef_bot_reg <= cfg_data;
                c3cf_pkg::CFG_RECIP:    recip_reg    <= cfg_data[23:0];
                c3cf_pkg::CFG_WIDTH:    width_reg    <= cfg_data[10:0];
                c3cf_pkg::CFG_HEIGHT:   height_reg   <= cfg_data[11:0];
                c3cf_pkg::CFG_CHANS:    chans_reg    <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    c3cf_front #(
        .MAX_LINE  (MAX_LINE),
        .MAX_CHANS (MAX_CHANS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .channel_count (chans_reg),
        .job           (push_job),
        .push          (q_push),
        .q_full        (q_full)
    );

    c3cf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_ne),
        .head      (head_job)
    );

    c3cf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_valid     (q_ne),
        .job           (head_job),
        .pop           (q_pop),
        .coef_row_top  (coef_top_reg),
        .coef_row_mid  (coef_mid_reg),
        .coef_row_bot  (coef_bot_reg),
        .recip_divisor (recip_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for conv3x3_clamp_filter: random frames checked against a built-in filter predictor.
module tb;

    localparam int LINE_MAX   = 1920;
    localparam int CHAN_MAX   = 3;
    localparam int CYCLE_CAP  = 3000000;
    localparam int RAND_ITEMS = 1400;
    localparam int TALL_ROWS  = 100;

    typedef struct {
        logic [23:0] pix;
        logic        frame_end;
    } pix_out_t;

    class frame_scoreboard;
        logic [47:0] coef_rows[3];
        logic [23:0] recip;
        logic [10:0] width_reg;
        logic [11:0] height_reg;
        logic [1:0]  chans_reg;
        logic [23:0] line_buf[2*LINE_MAX];
        logic [23:0] win[9];
        int unsigned in_row, in_col, out_row, out_col;
        pix_out_t    pending_pix[$];
        int          errors;

        function new();
            coef_rows[0] = 48'd0;
            coef_rows[1] = 48'd256;
            coef_rows[2] = 48'd0;
            recip = 24'd65536;
            width_reg = 11'd1920;
            height_reg = 12'd1080;
            chans_reg = 2'd3;
            foreach (line_buf[i]) line_buf[i] = '0;
            foreach (win[i]) win[i] = '0;
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [47:0] val);
            case (idx)
                c3cf_pkg::CFG_COEF_TOP: coef_rows[0] = val;
                c3cf_pkg::CFG_COEF_MID: coef_rows[1] = val;
                c3cf_pkg::CFG_COEF_BOT: coef_rows[2] = val;
                c3cf_pkg::CFG_RECIP:    recip = val[23:0];
                c3cf_pkg::CFG_WIDTH:    width_reg = val[10:0];
                c3cf_pkg::CFG_HEIGHT:   height_reg = val[11:0];
                c3cf_pkg::CFG_CHANS:    chans_reg = val[1:0];
                default: ;
            endcase
        endfunction

        function int unsigned eff_w();
            if (width_reg < 3) return 3;
            if (width_reg > LINE_MAX) return LINE_MAX;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            return (height_reg < 3) ? 3 : height_reg;
        endfunction

        function int unsigned eff_chans();
            int unsigned c;
            c = chans_reg;
            if (c == 0) c = 1;
            if (c > CHAN_MAX) c = CHAN_MAX;
            return c;
        endfunction

        function void shift_in(int unsigned col, logic [23:0] pix, bit store);
            int unsigned idx;
            logic [23:0] top, mid;
            idx = (col < eff_w()) ? col : 0;
            top = line_buf[idx];
            mid = line_buf[LINE_MAX + idx];
            if (store)
            begin
                line_buf[idx] = mid;
                line_buf[LINE_MAX + idx] = pix;
            end
            for (int i = 0; i < 3; i++)
            begin
                win[i*3] = win[i*3+1];
                win[i*3+1] = win[i*3+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = pix;
        endfunction

        function logic [7:0] weighted_chan(int k);
            int sum, c, p, rc;
            longint prod, q;
            sum = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    c = $signed(coef_rows[i][16*j +: 16]);
                    p = win[i*3+j][8*k +: 8];
                    sum += c * p;
                end
            rc = $signed(recip);
            prod = longint'(sum) * longint'(rc);
            if (prod <= 0) return 8'd0;
            q = prod >>> 24;
            return (q > 255) ? 8'd255 : q[7:0];
        endfunction

        function void emit_pixel();
            int unsigned w, h;
            bit interior, last;
            pix_out_t r;
            w = eff_w();
            h = eff_h();
            interior = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
            last = out_row + 1 >= h && out_col + 1 >= w;
            r.pix = '0;
            for (int k = 0; k < 3; k++)
                if (k < eff_chans())
                    r.pix[8*k +: 8] = interior ? weighted_chan(k) : win[4][8*k +: 8];
            r.frame_end = last;
            pending_pix.push_back(r);
            if (last)
            begin
                in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            end
            else
            begin
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row = (out_row + 1) & 12'hFFF;
                end
            end
        endfunction

        function void note_request(logic cmd, logic [23:0] data);
            int unsigned w, h;
            bit ready;
            w = eff_w();
            h = eff_h();
            if (cmd == c3cf_pkg::CMD_PIXEL)
            begin
                if (in_row >= h) return;
                ready = in_row >= 2 || (in_row == 1 && in_col >= 1);
                shift_in(in_col, data, 1'b1);
                in_col++;
                if (in_col >= w)
                begin
                    in_col = 0;
                    in_row = (in_row + 1) & 12'hFFF;
                end
                if (ready) emit_pixel();
            end
            else
            begin
                if (in_row < h) return;
                shift_in(in_col, 24'd0, 1'b0);
                in_col = (in_col + 1) & 11'h7FF;
                emit_pixel();
            end
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [23:0] data, logic frame_end);
            pix_out_t e;
            if (pending_pix.size() == 0)
            begin
                report($sformatf("unexpected pixel %h last=%0b", data, frame_end));
                return;
            end
            e = pending_pix.pop_front();
            for (int k = 0; k < 3; k++)
                if (data[8*k +: 8] !== e.pix[8*k +: 8])
                    report($sformatf("chan%0d got %h want %h", k, data[8*k +: 8],
                                     e.pix[8*k +: 8]));
            if (frame_end !== e.frame_end)
                report($sformatf("frame end got %b want %b", frame_end, e.frame_end));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // in_chan0, in_chan1, in_chan2
    logic        s_axis_tuser = c3cf_pkg::CMD_PIXEL;  // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;  // out_chan0, out_chan1, out_chan2
    logic        m_axis_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = c3cf_pkg::CFG_COEF_TOP;
    logic [47:0] cfg_data = '0;

    frame_scoreboard sb = new();
    int  cycles = 0;
    int  sent = 0;
    int  rx_hold = 0;
    bit  smooth = 1'b0;

    conv3x3_clamp_filter u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!smooth && $urandom_range(0, 3) == 0)
                rx_hold <= pick_gap();
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);

    // one request; caller sits at a rising edge
    task send(logic cmd, logic [23:0] data);
        int g;
        g = (!smooth && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (g > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= data;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(cmd, data);
        sent++;
    endtask

    task drain_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_pix.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task write_regs(logic [47:0] vals[7]);
        for (int i = 0; i < 7; i++)
        begin
            cfg_we <= 1'b1;
            cfg_idx <= i[2:0];
            cfg_data <= vals[i];
            sb.write_reg(i[2:0], vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // full frame plus drain flushes; noise adds ignored requests
    task run_frame(bit noise, bit pause_mid, logic [23:0] fixed_pix[$]);
        int unsigned n;
        logic [23:0] px;
        n = sb.eff_w() * sb.eff_h();
        for (int unsigned i = 0; i < n; i++)
        begin
            if (noise && $urandom_range(0, 15) == 0)
                send(c3cf_pkg::CMD_FLUSH, 24'($urandom()));
            px = (i < fixed_pix.size()) ? fixed_pix[i] : 24'($urandom());
            send(c3cf_pkg::CMD_PIXEL, px);
            if (pause_mid && i == n / 2)
            begin
                s_axis_tvalid <= 1'b0;
                do @(posedge clk); while (sb.pending_pix.size() != 0);
            end
        end
        if (noise) send(c3cf_pkg::CMD_PIXEL, 24'($urandom()));
        for (int unsigned i = 0; i <= sb.eff_w(); i++)
            send(c3cf_pkg::CMD_FLUSH, 24'($urandom()));
        if (noise && $urandom_range(0, 1) == 0) send(c3cf_pkg::CMD_FLUSH, 24'($urandom()));
        drain_idle();
    endtask

    initial
    begin
        logic [47:0] regs[7];
        logic [23:0] pat[$];
        logic [23:0] none[$];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity kernel, 3x3 frame, extreme pixel values, ignored requests
        regs = '{48'd0, 48'd256 << 16, 48'd0, 48'd65536, 48'd3, 48'd3, 48'd3};
        write_regs(regs);
        pat = '{24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'hFF00FF,
                24'h00FF00, 24'h123456, 24'hFEDCBA, 24'h808080};
        run_frame(1'b1, 1'b1, pat);

        // saturating extremes and out-of-range geometry
        regs = '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                 48'h80_0000, 48'd0, 48'd0, 48'd0};
        write_regs(regs);
        run_frame(1'b1, 1'b0, pat);
        regs = '{48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                 48'h7F_FFFF, 48'd60, 48'd3, 48'd2};
        write_regs(regs);
        run_frame(1'b0, 1'b0, none);

        while (sent < RAND_ITEMS - 3 * TALL_ROWS)
        begin
            smooth = ($urandom_range(0, 4) == 0);
            for (int r = 0; r < 3; r++)
                regs[r] = ($urandom_range(0, 3) == 0) ?
                          {16'd0, (($urandom_range(0, 1) == 0) ? 16'd0 : 16'd256), 16'd0} :
                          rand48();
            case ($urandom_range(0, 3))
                0: regs[3] = 48'd65536;
                1: regs[3] = 48'($urandom_range(0, 4096));
                default: regs[3] = 48'($urandom() & 24'hFFFFFF);
            endcase
            regs[4] = ($urandom_range(0, 9) == 0) ? 48'($urandom_range(0, 2))
                                                  : 48'($urandom_range(3, 10));
            regs[5] = ($urandom_range(0, 9) == 0) ? 48'($urandom_range(0, 2))
                                                  : 48'($urandom_range(3, 7));
            regs[6] = 48'($urandom_range(0, 3));
            write_regs(regs);
            run_frame($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0, none);
        end

        // tall narrow frame
        smooth = 1'b0;
        regs = '{rand48(), rand48(), rand48(), 48'd65536, 48'd3, 48'(TALL_ROWS), 48'd3};
        write_regs(regs);
        run_frame(1'b0, 1'b0, none);

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
